/* rtl/assert_macros.svh */
// Assertion helpers included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* rtl/isaac_pkg.sv */
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared types, constants and mix functions of the ISAAC generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isaac_pkg;

	localparam int POOL_LOG2_DEF = 8;
	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_SEEDED = 2'd1,
		MODE_FIXED  = 2'd2,
		MODE_NEXT   = 2'd3
	} mode_t;

	typedef logic [7:0][31:0] words8_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] word;
	} res_t;

	// One round of the eight-word golden-ratio mix
	function automatic words8_t mix_round(words8_t v, logic [2:0] r);
		words8_t     o;
		logic [2:0]  r1;
		logic [2:0]  r2;
		logic [2:0]  r3;
		logic [31:0] s;
		logic [31:0] t;
		o  = v;
		r1 = r + 3'd1;
		r2 = r + 3'd2;
		r3 = r + 3'd3;
		unique case (r)
			3'd0: s = v[1] << 11;
			3'd1: s = v[2] >> 2;
			3'd2: s = v[3] << 8;
			3'd3: s = v[4] >> 16;
			3'd4: s = v[5] << 10;
			3'd5: s = v[6] >> 4;
			3'd6: s = v[7] << 8;
			default: s = v[0] >> 9;
		endcase
		t     = v[r] ^ s;
		o[r]  = t;
		o[r3] = v[r3] + t;
		o[r1] = v[r1] + v[r2];
		return o;
	endfunction

	// Accumulator scramble chosen by the low position bits
	function automatic logic [31:0] a_mix(logic [31:0] a, logic [1:0] p);
		logic [31:0] r;
		unique case (p)
			2'd0: r = a ^ (a << 13);
			2'd1: r = a ^ (a >> 6);
			2'd2: r = a ^ (a << 2);
			default: r = a ^ (a >> 16);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/isaac_spram.sv */
// ----------------------------------------------------------------------------
// isaac_spram
// Single-port word memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isaac_spram #(
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [31:0]   wdata,
	output logic [31:0]        rdata
);

	logic [31:0] mem [1<<AW];

	// Write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/isaac_seq.sv */
// ----------------------------------------------------------------------------
// isaac_seq
// Sequencer: clearing pass, seed loads, initialisation and ISAAC steps over
// the pool and seed memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isaac_seq #(
	parameter int POOL_LOG2 = isaac_pkg::POOL_LOG2_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  seed_index,
	input  wire logic [31:0] seed_value,
	input  wire logic        out_full,
	output isaac_pkg::res_t  res
);
	import isaac_pkg::*;

	localparam int P = POOL_LOG2;
	localparam logic [P-1:0] HALF = P'(1 << (P - 1));
	localparam logic [P-1:0] LAST = P'((1 << P) - 1);
	localparam logic [P-4:0] LAST_BLK = (P-3)'((1 << (P - 3)) - 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_IM, S_FR, S_FM, S_FW
	} state_t;

	state_t        state_q;
	logic [P-1:0]  pos_q;
	logic [P-1:0]  clr_q;
	logic [31:0]   acc_a_q;
	logic [31:0]   acc_b_q;
	logic [31:0]   gc_q;
	logic          grp_q;
	logic [31:0]   x_q;
	logic [31:0]   a_q;
	logic [31:0]   y_q;
	words8_t       v_q;
	logic [2:0]    rnd_q;
	logic [1:0]    mcnt_q;
	logic [3:0]    k_q;
	logic [P-4:0]  blk_q;
	logic          seeded_q;
	logic          pass_q;

	logic          p_en;
	logic          p_we;
	logic [P-1:0]  p_addr;
	logic [31:0]   p_wdata;
	logic [31:0]   p_rd;
	logic          s_en;
	logic          s_we;
	logic [P-1:0]  s_addr;
	logic [31:0]   s_wdata;
	logic [31:0]   s_rd;
	logic [P-1:0]  blk_addr;
	logic [31:0]   y_next;
	logic [31:0]   b_next;
	logic [31:0]   src_rd;

	isaac_spram #(.AW(P)) u_pool (
		.clk(clk), .en(p_en), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rd)
	);

	isaac_spram #(.AW(P)) u_seed (
		.clk(clk), .en(s_en), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rd)
	);

	assign blk_addr = {blk_q, k_q[2:0]};
	assign y_next   = p_rd + a_q + acc_b_q;
	assign b_next   = p_rd + x_q;
	assign src_rd   = pass_q ? p_rd : s_rd;
	assign in_ready = (state_q == S_IDLE);
	assign res.valid = (state_q == S_T5) && !out_full;
	assign res.word  = b_next;

	// Drive memory ports from the current state
	always_comb begin
		p_en    = 1'b0;
		p_we    = 1'b0;
		p_addr  = pos_q;
		p_wdata = '0;
		s_en    = 1'b0;
		s_we    = 1'b0;
		s_addr  = pos_q;
		s_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				p_en   = 1'b1;
				p_we   = 1'b1;
				p_addr = clr_q;
				s_en   = 1'b1;
				s_we   = 1'b1;
				s_addr = clr_q;
			end
			S_IDLE: begin
				if (in_valid && mode_t'(mode) == MODE_LOAD) begin
					s_en    = 1'b1;
					s_we    = 1'b1;
					s_addr  = P'(seed_index);
					s_wdata = seed_value;
				end
			end
			S_T0: p_en = 1'b1;
			S_T1: begin
				p_en   = 1'b1;
				p_addr = pos_q + HALF;
			end
			S_T2: begin
				p_en   = 1'b1;
				p_addr = x_q[P+1:2];
			end
			S_T3: begin
				p_en    = 1'b1;
				p_we    = 1'b1;
				p_wdata = y_next;
			end
			S_T4: begin
				p_en   = 1'b1;
				p_addr = y_q[2*P+1:P+2];
			end
			S_T5: begin
				if (!out_full) begin
					s_en    = 1'b1;
					s_we    = 1'b1;
					s_wdata = b_next;
				end
			end
			S_FR: begin
				if (!k_q[3]) begin
					p_en   = pass_q;
					p_addr = blk_addr;
					s_en   = !pass_q;
					s_addr = blk_addr;
				end
			end
			S_FW: begin
				p_en    = 1'b1;
				p_we    = 1'b1;
				p_addr  = blk_addr;
				p_wdata = v_q[k_q[2:0]];
			end
			default: begin
			end
		endcase
	end

	// Hold state and advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			pos_q    <= '0;
			acc_a_q  <= '0;
			acc_b_q  <= '0;
			gc_q     <= '0;
			grp_q    <= 1'b0;
			rnd_q    <= '0;
			mcnt_q   <= '0;
			k_q      <= '0;
			blk_q    <= '0;
			seeded_q <= 1'b0;
			pass_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						unique case (mode_t'(mode))
							MODE_LOAD: state_q <= S_IDLE;
							MODE_SEEDED, MODE_FIXED: begin
								seeded_q <= (mode_t'(mode) == MODE_SEEDED);
								acc_a_q  <= '0;
								acc_b_q  <= '0;
								gc_q     <= '0;
								pos_q    <= '0;
								pass_q   <= 1'b0;
								rnd_q    <= '0;
								mcnt_q   <= '0;
								blk_q    <= '0;
								k_q      <= '0;
								v_q      <= {8{GOLDEN}};
								state_q  <= S_IM;
							end
							default: state_q <= S_T0;
						endcase
					end
				end
				S_T0: begin
					grp_q <= (pos_q == '0);
					if (pos_q == '0) begin
						gc_q <= gc_q + 32'd1;
					end
					state_q <= S_T1;
				end
				S_T1: begin
					x_q <= p_rd;
					if (grp_q) begin
						acc_b_q <= acc_b_q + gc_q;
					end
					state_q <= S_T2;
				end
				S_T2: begin
					a_q     <= a_mix(acc_a_q, pos_q[1:0]) + p_rd;
					state_q <= S_T3;
				end
				S_T3: begin
					y_q     <= y_next;
					state_q <= S_T4;
				end
				S_T4: state_q <= S_T5;
				S_T5: begin
					if (!out_full) begin
						acc_b_q <= b_next;
						acc_a_q <= a_q;
						pos_q   <= pos_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_IM: begin
					v_q   <= mix_round(v_q, rnd_q);
					rnd_q <= rnd_q + 3'd1;
					if (rnd_q == 3'd7) begin
						mcnt_q <= mcnt_q + 2'd1;
						if (mcnt_q == 2'd3) begin
							state_q <= seeded_q ? S_FR : S_FM;
						end
					end
				end
				S_FR: begin
					if (k_q != 4'd0) begin
						v_q[k_q[2:0] - 3'd1] <= v_q[k_q[2:0] - 3'd1] + src_rd;
					end
					if (k_q[3]) begin
						k_q     <= '0;
						rnd_q   <= '0;
						state_q <= S_FM;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_FM: begin
					v_q   <= mix_round(v_q, rnd_q);
					rnd_q <= rnd_q + 3'd1;
					if (rnd_q == 3'd7) begin
						k_q     <= '0;
						state_q <= S_FW;
					end
				end
				S_FW: begin
					k_q <= k_q + 4'd1;
					if (k_q[2:0] == 3'd7) begin
						k_q <= '0;
						if (blk_q == LAST_BLK) begin
							blk_q <= '0;
							if (seeded_q && !pass_q) begin
								pass_q  <= 1'b1;
								state_q <= S_FR;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							blk_q   <= blk_q + 1'b1;
							state_q <= seeded_q ? S_FR : S_FM;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/isaac_random_generator_top.sv */
// ----------------------------------------------------------------------------
// isaac_random_generator_top
// ISAAC generator, 32-bit words, pool and seed store in single-port memories.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid/in_ready) carries mode, seed_index and
//   seed_value. Mode 0 loads a seed word; modes 1 and 2 rebuild the pool;
//   mode 3 returns one word on the result channel
//   (out_valid/out_ready, random_word).
//   A next-word request passes through states T0 to T5 before the result is
//   registered; the single pool port carries three reads, one write and a
//   read after that write in sequence. Words come out in generation order.
//   Fixed and seeded init mix the golden-ratio words and fill the pool block
//   by block; the eight-word mix runs one round per cycle.
//   After reset a clearing pass writes zero through every entry of both
//   memories, one entry a cycle; in_ready stays low meanwhile.
//   One result may wait in the output register while the next request is
//   accepted; if it has not been taken when the next word is done, the
//   step holds in its last cycle until the receiver frees the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module isaac_random_generator_top #(
	parameter int POOL_LOG2 = isaac_pkg::POOL_LOG2_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  seed_index,
	input  wire logic [31:0] seed_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      random_word
);
	import isaac_pkg::*;

	res_t res;
	logic out_full;
	logic out_valid_q;
	logic [31:0] word_q;

	assign out_full    = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign random_word = word_q;

	isaac_seq #(.POOL_LOG2(POOL_LOG2)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .seed_index(seed_index), .seed_value(seed_value),
		.out_full(out_full), .res(res)
	);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			word_q <= res.word;
		end
	end

	`ASSERT_CLK(a_no_overwrite, clk, arst_n, res.valid |-> !out_full, "result overwrites a held word")
	`ASSERT_CLK(a_idle_no_res, clk, arst_n, in_ready |-> !res.valid, "result while idle")
	`ASSERT_CLK(a_res_sets_out, clk, arst_n, res.valid |=> out_valid, "result not registered")

endmodule

`default_nettype wire

/* bench/isaac_random_generator_top_tb.sv */
// ----------------------------------------------------------------------------
// isaac_random_generator_top_tb
// Drives load, seeded init, fixed init and next-word requests into the ISAAC
// generator and compares every returned word with a local model of the pool,
// seed store and accumulators. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isaac_random_generator_top_tb;
	import isaac_pkg::*;

	localparam int PSIZE = 256;
	localparam int PMASK = PSIZE - 1;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_LOAD;
	logic [7:0]  seed_index = '0;
	logic [31:0] seed_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] random_word;

	isaac_random_generator_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .seed_index(seed_index), .seed_value(seed_value),
		.out_valid(out_valid), .out_ready(out_ready), .random_word(random_word)
	);

	always #1 clk = ~clk;

	// Local copy of the generator state
	logic [31:0] gen_pool [PSIZE];
	logic [31:0] gen_seeds [PSIZE];
	logic [31:0] gen_a, gen_b, gen_c;
	logic [7:0]  gen_pos;
	logic [31:0] words_due [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          send_idle = 30;
	int          recv_idle = 65;

	// Golden-ratio mix over eight words
	function automatic void mix_eight(ref logic [31:0] v [8]);
		v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
		v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
		v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
		v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
		v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
		v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
		v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
		v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
	endfunction

	// Rebuild the pool; seeded runs two passes over seeds then pool
	task automatic rebuild_pool(input bit seeded);
		logic [31:0] v [8];
		logic [31:0] src [PSIZE];
		gen_a = '0; gen_b = '0; gen_c = '0; gen_pos = '0;
		for (int k = 0; k < 8; k++) v[k] = GOLDEN;
		for (int k = 0; k < 4; k++) mix_eight(v);
		for (int p = 0; p < (seeded ? 2 : 1); p++) begin
			for (int i = 0; i < PSIZE; i++) src[i] = (p == 0) ? gen_seeds[i] : gen_pool[i];
			for (int i = 0; i < PSIZE; i += 8) begin
				if (seeded) for (int k = 0; k < 8; k++) v[k] += src[i + k];
				mix_eight(v);
				for (int k = 0; k < 8; k++) gen_pool[i + k] = v[k];
			end
		end
	endtask

	// One ISAAC step; returns the produced word
	function automatic logic [31:0] next_word();
		logic [31:0] x, y, a;
		int p;
		p = gen_pos;
		if (p == 0) begin
			gen_c = gen_c + 32'd1;
			gen_b = gen_b + gen_c;
		end
		x = gen_pool[p];
		a = gen_a;
		case (p & 3)
			0: a ^= a << 13;
			1: a ^= a >> 6;
			2: a ^= a << 2;
			default: a ^= a >> 16;
		endcase
		a = a + gen_pool[(p + PSIZE / 2) & PMASK];
		y = gen_pool[(x >> 2) & PMASK] + a + gen_b;
		gen_pool[p] = y;
		gen_b = gen_pool[(y >> 10) & PMASK] + x;
		gen_a = a;
		gen_seeds[p] = gen_b;
		gen_pos = gen_pos + 8'd1;
		return gen_b;
	endfunction

	// Update the model for one accepted request
	task automatic predict(input logic [1:0] m, input logic [7:0] idx, input logic [31:0] val);
		case (m)
			MODE_LOAD:   gen_seeds[idx] = val;
			MODE_SEEDED: rebuild_pool(1'b1);
			MODE_FIXED:  rebuild_pool(1'b0);
			default:     words_due.push_back(next_word());
		endcase
	endtask

	// Send one request and hold it until accepted; drop valid only while idling
	task automatic send(input logic [1:0] m, input logic [7:0] idx, input logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= m; seed_index <= idx; seed_value <= val; in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict(m, idx, val);
		@(negedge clk);
	endtask

	// Receiver stalls
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

	// Check results against the oldest expected word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", random_word);
			end else begin
				if (random_word !== words_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: expected %h got %h", words_due[0], random_word);
				end
				void'(words_due.pop_front());
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("isaac_random_generator_top_tb: errors");
			$finish;
		end
	end

	typedef struct {
		logic [1:0]  m;
		logic [7:0]  idx;
		logic [31:0] val;
		bit          known;
		logic [31:0] word;
	} row_t;

	// Directed table; the first word after reset from an all-zero pool is one
	row_t rows [] = '{
		'{MODE_NEXT,   8'd0,   32'h0,        1'b1, 32'h1},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_FIXED,  8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_LOAD,   8'd0,   32'hffffffff, 1'b0, 32'h0},
		'{MODE_LOAD,   8'd255, 32'hffffffff, 1'b0, 32'h0},
		'{MODE_LOAD,   8'd128, 32'h0,        1'b0, 32'h0},
		'{MODE_LOAD,   8'd85,  32'haaaaaaaa, 1'b0, 32'h0},
		'{MODE_LOAD,   8'd170, 32'h55555555, 1'b0, 32'h0},
		'{MODE_SEEDED, 8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_SEEDED, 8'd0,   32'h0,        1'b0, 32'h0},
		'{MODE_NEXT,   8'd0,   32'h0,        1'b0, 32'h0}
	};

	initial begin
		int r;
		for (int i = 0; i < PSIZE; i++) begin
			gen_pool[i] = '0;
			gen_seeds[i] = '0;
		end
		gen_a = '0; gen_b = '0; gen_c = '0; gen_pos = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			send(rows[i].m, rows[i].idx, rows[i].val);
			if (rows[i].known && rows[i].word !== words_due[words_due.size() - 1]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: expected %h predicted %h", i, rows[i].word,
						words_due[words_due.size() - 1]);
			end
		end

		// Random part in three idling phases; mostly next-word requests
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 65; recv_idle = 30; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			for (int n = 0; n < 510; n++) begin
				r = $urandom_range(99);
				if (r < 75)
					send(MODE_NEXT, 8'($urandom), 32'($urandom));
				else if (r < 97)
					send(MODE_LOAD, 8'($urandom), 32'($urandom));
				else if (r < 99)
					send(MODE_SEEDED, 8'($urandom), 32'($urandom));
				else
					send(MODE_FIXED, 8'($urandom), 32'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (words_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && words_due.size() == 0)
			$display("isaac_random_generator_top_tb: clean");
		else
			$display("isaac_random_generator_top_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/isaac_pkg.sv
rtl/isaac_spram.sv
rtl/isaac_seq.sv
rtl/isaac_random_generator_top.sv
bench/isaac_random_generator_top_tb.sv
